[rtl/cca_pkg.sv]
// Shared types, constants and helpers for the calendar clock with alarms.
package cca_pkg;

  localparam int ALARM_SLOTS_DEF = 8;
  localparam int EVENT_SLOTS_DEF = 16;

  localparam int SEC_PER_MIN     = 60;
  localparam int MIN_PER_HOUR    = 60;
  localparam int HOUR_PER_DAY    = 24;
  localparam int MONTHS_PER_YEAR = 12;
  localparam int YEAR_LAST       = 9999;

  // y % 25 == 0  <=>  (y * inv(25) mod 2^14) <= floor((2^14 - 1) / 25)
  localparam logic [13:0] DIV25_INV = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SET_TIME = 3'd1,
    OP_WR_ALARM = 3'd2,
    OP_WR_EVENT = 3'd3,
    OP_SET_ACNT = 3'd4,
    OP_SET_ECNT = 3'd5
  } op_e;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_ALARM    = 2'd1;
  localparam logic [1:0] KIND_REMINDER = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  slot;
    logic        enable;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_t;

  typedef struct packed {
    logic [1:0]  popup_kind;
    logic [3:0]  popup_slot;
    logic [13:0] now_year;
    logic [3:0]  now_month;
    logic [4:0]  now_day;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
  } out_t;

  typedef struct packed {
    logic        enable;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } alarm_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } evt_t;

  typedef struct packed {
    logic capture;
    logic load_leap;
    logic clr_popup;
    logic apply;
    logic advance;
    logic a_start;
    logic e_start;
    logic a_step;
    logic e_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic minute_roll;
    logic scan_done;
  } sts_t;

  // Out-of-range months count as 31 days.
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

[rtl/cca_dp.sv]
// Datapath: clock registers, alarm and event stores, table scan and result register.
module cca_dp #(
  parameter int ALARM_SLOTS = cca_pkg::ALARM_SLOTS_DEF,
  parameter int EVENT_SLOTS = cca_pkg::EVENT_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cca_pkg::in_t  in_i,
  input  cca_pkg::cmd_t cmd_i,
  output cca_pkg::sts_t sts_o,
  output cca_pkg::out_t out_o
);
  import cca_pkg::*;

  localparam int AIW = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
  localparam int EIW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int ACW = $clog2(ALARM_SLOTS + 1);
  localparam int ECW = $clog2(EVENT_SLOTS + 1);
  localparam int SCW = (ACW > ECW) ? ACW : ECW;

  in_t         in_q;
  logic        leap_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q, day_q;
  logic [3:0]  mon_q;
  logic [13:0] year_q;
  logic [ACW-1:0] a_cnt_q;
  logic [ECW-1:0] e_cnt_q;

  alarm_t a_mem [ALARM_SLOTS];
  evt_t   e_mem [EVENT_SLOTS];
  alarm_t a_rd_q;
  evt_t   e_rd_q;

  logic [SCW-1:0] scan_q, scan_m1, cmp_idx_q;
  logic           cmp_vld_q;
  logic [SCW+3:0] cmp_ext;
  logic [1:0]     kind_q;
  logic [3:0]     pslot_q;
  out_t           out_q;

  logic [13:0] div_prod;
  logic        leap_d;

  logic [6:0]  sec_inc, min_inc;
  logic [5:0]  hour_inc, day_inc;
  logic [4:0]  mon_inc;
  logic [5:0]  adv_sec, adv_min;
  logic [4:0]  adv_hour, adv_day;
  logic [3:0]  adv_mon;
  logic [13:0] adv_year;

  logic [AIW+4:0] a_slot_ext;
  logic [EIW+4:0] e_slot_ext;
  logic           a_wr, e_wr, set_time;

  logic issue, a_match, e_match, hit;

  // Leap year from a divisibility test by 25 plus low-bit masks.
  assign div_prod = year_q * DIV25_INV;
  assign leap_d   = (year_q[1:0] == 2'b00) && ((div_prod > DIV25_MAX) || (year_q[3:0] == 4'h0));

  assign sec_inc  = {1'b0, sec_q} + 7'd1;
  assign min_inc  = {1'b0, min_q} + 7'd1;
  assign hour_inc = {1'b0, hour_q} + 6'd1;
  assign day_inc  = {1'b0, day_q} + 6'd1;
  assign mon_inc  = {1'b0, mon_q} + 5'd1;

  always_comb begin
    adv_sec  = sec_inc[5:0];
    adv_min  = min_q;
    adv_hour = hour_q;
    adv_day  = day_q;
    adv_mon  = mon_q;
    adv_year = year_q;
    if (sec_inc >= 7'(SEC_PER_MIN)) begin
      adv_sec = '0;
      adv_min = min_inc[5:0];
      if (min_inc >= 7'(MIN_PER_HOUR)) begin
        adv_min  = '0;
        adv_hour = hour_inc[4:0];
        if (hour_inc >= 6'(HOUR_PER_DAY)) begin
          adv_hour = '0;
          adv_day  = day_inc[4:0];
          if (day_inc > {1'b0, days_in_month(mon_q, leap_q)}) begin
            adv_day = 5'd1;
            adv_mon = mon_inc[3:0];
            if (mon_inc > 5'(MONTHS_PER_YEAR)) begin
              adv_mon  = 4'd1;
              adv_year = (year_q >= 14'(YEAR_LAST)) ? '0 : year_q + 14'd1;
            end
          end
        end
      end
    end
  end

  assign a_slot_ext = {{AIW{1'b0}}, in_q.slot};
  assign e_slot_ext = {{EIW{1'b0}}, in_q.slot};
  assign set_time   = cmd_i.apply && (op_e'(in_q.op) == OP_SET_TIME);
  assign a_wr = cmd_i.apply && (op_e'(in_q.op) == OP_WR_ALARM) &&
                (32'(in_q.slot) < ALARM_SLOTS);
  assign e_wr = cmd_i.apply && (op_e'(in_q.op) == OP_WR_EVENT) &&
                (32'(in_q.slot) < EVENT_SLOTS);

  // Scan: one read issued per step, compared the cycle after.
  assign scan_m1 = scan_q - SCW'(1);
  assign issue   = cmd_i.a_step ? (scan_q < SCW'(a_cnt_q)) : (scan_q != '0);
  assign a_match = a_rd_q.enable && (a_rd_q.hour == hour_q) && (a_rd_q.minute == min_q);
  assign e_match = (e_rd_q.year == year_q) && (e_rd_q.month == mon_q) &&
                   (e_rd_q.day == day_q) && (e_rd_q.hour == hour_q) &&
                   (e_rd_q.minute == min_q);
  assign hit     = cmp_vld_q && ((cmd_i.a_step && a_match) || (cmd_i.e_step && e_match));
  assign cmp_ext = {4'b0000, cmp_idx_q};

  assign sts_o.op          = op_e'(in_q.op);
  assign sts_o.minute_roll = sec_inc >= 7'(SEC_PER_MIN);
  assign sts_o.scan_done   = hit || !issue;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q     <= '0;
      min_q     <= '0;
      hour_q    <= '0;
      day_q     <= 5'd1;
      mon_q     <= 4'd1;
      year_q    <= 14'd2024;
      a_cnt_q   <= '0;
      e_cnt_q   <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (set_time) begin
        sec_q  <= in_q.second;
        min_q  <= in_q.minute;
        hour_q <= in_q.hour;
        day_q  <= in_q.day;
        mon_q  <= in_q.month;
        year_q <= in_q.year;
      end else if (cmd_i.advance) begin
        sec_q  <= adv_sec;
        min_q  <= adv_min;
        hour_q <= adv_hour;
        day_q  <= adv_day;
        mon_q  <= adv_mon;
        year_q <= adv_year;
      end
      if (cmd_i.apply && (op_e'(in_q.op) == OP_SET_ACNT)) begin
        a_cnt_q <= (32'(in_q.slot) > ALARM_SLOTS) ? ACW'(ALARM_SLOTS) : ACW'(in_q.slot);
      end
      if (cmd_i.apply && (op_e'(in_q.op) == OP_SET_ECNT)) begin
        e_cnt_q <= (32'(in_q.slot) > EVENT_SLOTS) ? ECW'(EVENT_SLOTS) : ECW'(in_q.slot);
      end else if (cmd_i.e_step && hit) begin
        e_cnt_q <= cmp_idx_q[ECW-1:0];
      end
      if (cmd_i.a_start) begin
        scan_q    <= '0;
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.e_start) begin
        scan_q    <= SCW'(e_cnt_q);
        cmp_vld_q <= 1'b0;
      end else if (cmd_i.a_step || cmd_i.e_step) begin
        cmp_vld_q <= issue;
        if (issue) begin
          scan_q <= cmd_i.a_step ? scan_q + SCW'(1) : scan_m1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_i;
    end
    if (cmd_i.load_leap) begin
      leap_q <= leap_d;
    end
    if (cmd_i.a_step || cmd_i.e_step) begin
      cmp_idx_q <= cmd_i.a_step ? scan_q : scan_m1;
    end
    if (cmd_i.clr_popup) begin
      kind_q  <= KIND_NONE;
      pslot_q <= '0;
    end else if (hit) begin
      kind_q  <= cmd_i.a_step ? KIND_ALARM : KIND_REMINDER;
      pslot_q <= cmp_ext[3:0];
    end
    if (cmd_i.out_load) begin
      out_q.popup_kind <= kind_q;
      out_q.popup_slot <= pslot_q;
      out_q.now_year   <= year_q;
      out_q.now_month  <= mon_q;
      out_q.now_day    <= day_q;
      out_q.now_hour   <= hour_q;
      out_q.now_minute <= min_q;
      out_q.now_second <= sec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_wr) begin
      a_mem[a_slot_ext[AIW-1:0]] <= '{enable: in_q.enable, hour: in_q.hour,
                                     minute: in_q.minute};
    end
    if (cmd_i.a_step && issue) begin
      a_rd_q <= a_mem[scan_q[AIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_wr) begin
      e_mem[e_slot_ext[EIW-1:0]] <= '{year: in_q.year, month: in_q.month, day: in_q.day,
                                     hour: in_q.hour, minute: in_q.minute};
    end
    if (cmd_i.e_step && issue) begin
      e_rd_q <= e_mem[scan_m1[EIW-1:0]];
    end
  end

  assign out_o = out_q;

endmodule

[rtl/cca_ctrl.sv]
// Controller: sequences decode, carry, both table scans and the result transfer.
module cca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_stall_i,
  input  cca_pkg::sts_t sts_i,
  output cca_pkg::cmd_t cmd_o,
  output logic          in_stall_o,
  output logic          out_valid_o
);
  import cca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_ADV,
    S_ASTART,
    S_ASCAN,
    S_ESTART,
    S_ESCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.load_leap = 1'b1;
        cmd_o.clr_popup = 1'b1;
        unique case (sts_i.op)
          OP_TICK: state_d = S_ADV;
          default: begin
            cmd_o.apply = 1'b1;
            state_d     = S_DONE;
          end
        endcase
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = sts_i.minute_roll ? S_ASTART : S_DONE;
      end
      S_ASTART: begin
        cmd_o.a_start = 1'b1;
        state_d       = S_ASCAN;
      end
      S_ASCAN: begin
        cmd_o.a_step = 1'b1;
        if (sts_i.scan_done) state_d = S_ESTART;
      end
      S_ESTART: begin
        cmd_o.e_start = 1'b1;
        state_d       = S_ESCAN;
      end
      S_ESCAN: begin
        cmd_o.e_step = 1'b1;
        if (sts_i.scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/calendar_clock_with_alarms.sv]
// Top level of the calendar clock with alarm and one-shot reminder tables.
//
// Input channel in_valid_i/in_stall_o carries one command (tick, set time,
// table write or count update); output channel out_valid_o/out_stall_i
// returns exactly one result per command: the popup and the clock after it.
// A command is taken only while the block is idle and then runs alone; the
// next can be taken the cycle after its result is loaded.
// Every command passes decode; a non-tick command then loads its result, and
// a tick first advances the clock. A tick that rolls the minute then starts
// and runs the alarm scan and then the event scan over the alarm and event
// counts before the result is loaded (a match ends a scan early). The scans
// read one table entry per cycle through each store's single read port.
// The result sits in an output register, so the next command is taken while
// an earlier result waits; a stalled receiver only holds the block once a
// second result is ready. Reset sets the clock to 2024-01-01 00:00:00 and
// both counts to zero; table contents are undefined until written.
module calendar_clock_with_alarms #(
  parameter int ALARM_SLOTS = cca_pkg::ALARM_SLOTS_DEF,
  parameter int EVENT_SLOTS = cca_pkg::EVENT_SLOTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cca_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cca_pkg::out_t out_o
);
  import cca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  cca_dp #(
    .ALARM_SLOTS (ALARM_SLOTS),
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  a_in_transfer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a command is still in flight");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  a_one_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.a_step && cmd.e_step))
    else $error("both table scans active together");

  a_no_popup_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.popup_kind == KIND_NONE)) |-> (out_o.popup_slot == 4'd0))
    else $error("slot reported without a popup");

endmodule
